[rtl/tsm_pkg.sv]
// Shared types, constants and the circle sample generator for the tube mesh block.
`timescale 1ns / 1ps

package tsm_pkg;

    // Point counter width and configuration register indexes
    localparam int PC_W = 10;
    localparam logic [1:0] CFG_PATH_POINTS    = 2'd0;
    localparam logic [1:0] CFG_GEOMETRY_SCALE = 2'd1;
    localparam logic [1:0] CFG_TEX_V_STEP     = 2'd2;

    // CORDIC arctangent steps, binary angle with 2^32 per turn
    localparam longint CORDIC_ATAN [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       lxy;
        logic       mul;
        logic       add;
        logic       nrm_step;
        logic       sq_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       emit;
        logic [1:0] comp;
    } tsm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mx_zero;
        logic mx_hi;
        logic mx_lo;
        logic j_last;
        logic out_busy;
    } tsm_stat_t;

    // Cosine (upper half) and sine (lower half) in Q1.14 of a binary angle
    function automatic logic [31:0] circle_sample(input logic [31:0] ang);
        logic [31:0] q;
        logic [31:0] zu;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        longint      rc;
        longint      rs;
        q  = ((ang + 32'h2000_0000) >> 30) & 32'd3;
        zu = ang - (q << 30);
        z  = longint'($signed(zu));
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - CORDIC_ATAN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + CORDIC_ATAN[i];
            end
        end
        case (q[1:0])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        rc = (c + 32768) >>> 16;
        rs = (s + 32768) >>> 16;
        if (rc > 16384)  rc = 16384;
        if (rc < -16384) rc = -16384;
        if (rs > 16384)  rs = 16384;
        if (rs < -16384) rs = -16384;
        return {rc[15:0], rs[15:0]};
    endfunction

endpackage

[rtl/tsm_ctrl.sv]
// Sequencer that steps the datapath through each vertex of a ring.
`timescale 1ns / 1ps

module tsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsm_pkg::tsm_stat_t stat,
    output tsm_pkg::tsm_cmd_t  cmd
);
    import tsm_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LXY  = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_ADD  = 4'd3;
    localparam logic [3:0] ST_NRM  = 4'd4;
    localparam logic [3:0] ST_SQ   = 4'd5;
    localparam logic [3:0] ST_SQI  = 4'd6;
    localparam logic [3:0] ST_SQRT = 4'd7;
    localparam logic [3:0] ST_DIVI = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_DIVS = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] comp_reg;
    logic [1:0] comp_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LXY;
                end
            end
            ST_LXY:
            begin
                cmd.lxy    = 1'b1;
                comp_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_NRM;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_NRM:
            begin
                cmd.nrm_step = 1'b1;
                if (stat.mx_zero)
                begin
                    state_next = ST_EMIT;
                end
                else if (!stat.mx_hi && !stat.mx_lo)
                begin
                    step_next  = 5'd0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                cmd.comp    = step_reg[1:0];
                step_next   = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    state_next = ST_SQI;
                end
            end
            ST_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = 5'd0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    comp_next  = 2'd0;
                    state_next = ST_DIVI;
                end
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                step_next    = 5'd0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 5'd1;
                if (step_reg == 5'd15)
                begin
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                cmd.div_store = 1'b1;
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DIVI;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.j_last ? ST_IDLE : ST_LXY;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= 2'd0;
            step_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            step_reg  <= step_next;
        end
    end

    // Never overwrite a word the receiver has not taken
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !stat.out_busy)
        else $error("vertex emitted over a pending word");

    // Division always follows a finished square root
    a_div_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVI && comp_reg == 2'd0) |->
        ($past(state_reg) == ST_SQRT))
        else $error("division started without square root");

    // A new point is taken only after the last vertex of the ring went out
    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && $past(state_reg) == ST_EMIT) |-> $past(stat.j_last))
        else $error("new point taken mid ring");

endmodule

[rtl/tsm_dp.sv]
// Datapath: configuration, circle tables, transform, normalization and output word.
`timescale 1ns / 1ps

module tsm_dp #(
    parameter int RING_RES        = 16,
    parameter int MAX_PATH_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic [53:0]        xform_row_x,
    input  logic [53:0]        xform_row_y,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    input  logic signed [31:0] offset_z,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [15:0]        radius_factor,
    input  tsm_pkg::tsm_cmd_t  cmd,
    output tsm_pkg::tsm_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] nrm_x,
    output logic signed [15:0] nrm_y,
    output logic signed [15:0] nrm_z,
    output logic [15:0]        tex_u,
    output logic [23:0]        tex_v,
    output logic               quad_valid,
    output logic [19:0]        quad_index,
    output logic               ring_last
);
    import tsm_pkg::*;

    localparam int J_W = $clog2(RING_RES + 1);

    // Constant tables: circle samples and texture u per sample
    logic signed [15:0] cos_tab [0:RING_RES];
    logic signed [15:0] sin_tab [0:RING_RES];
    logic [15:0]        tu_tab  [0:RING_RES];

    for (genvar k = 0; k <= RING_RES; k++)
    begin : g_tab
        localparam int          KS  = (k == RING_RES) ? 0 : k;
        localparam logic [31:0] ANG = 32'((64'(KS) << 32) / RING_RES);
        localparam logic [31:0] CS  = circle_sample(ANG);
        localparam logic [15:0] TU  = 16'((k * 32768 + RING_RES / 2) / RING_RES);
        assign cos_tab[k] = CS[31:16];
        assign sin_tab[k] = CS[15:0];
        assign tu_tab[k]  = TU;
    end

    // Configuration and control registers
    logic [10:0]       path_points_reg;
    logic [15:0]       geometry_scale_reg;
    logic [23:0]       tex_v_step_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [J_W-1:0]    j_reg;
    logic              out_valid_reg;

    // Payload registers
    logic [53:0]        mrx_reg;
    logic [53:0]        mry_reg;
    logic signed [31:0] off_reg [0:2];
    logic signed [31:0] ctr_reg [0:2];
    logic [31:0]        sc_reg;
    logic [23:0]        tv_reg;
    logic [19:0]        base_reg;
    logic               last_reg;
    logic signed [33:0] lx_reg;
    logic signed [33:0] ly_reg;
    logic signed [51:0] pa_reg;
    logic signed [51:0] pb_reg;
    logic signed [31:0] pos_reg [0:2];
    logic [37:0]        mag_reg [0:2];
    logic               neg_reg [0:2];
    logic [37:0]        mx_reg;
    logic [59:0]        sq_reg;
    logic [61:0]        acc_reg;
    logic [61:0]        v_reg;
    logic [62:0]        r_reg;
    logic [62:0]        bit_reg;
    logic [31:0]        rem_reg;
    logic [15:0]        lo_reg;
    logic [15:0]        q_reg;
    logic signed [15:0] nrm_reg [0:2];

    logic signed [31:0] out_pos_reg [0:2];
    logic signed [15:0] out_nrm_reg [0:2];
    logic [15:0]        out_tu_reg;
    logic [23:0]        out_tv_reg;
    logic               out_qv_reg;
    logic [19:0]        out_qi_reg;
    logic               out_last_reg;

    // Load stage values
    logic [10:0] pts;
    logic [10:0] pc_inc;
    logic        last_load;
    logic [33:0] tv_full;

    always_comb
    begin
        if (path_points_reg < 11'd2)
            pts = 11'd2;
        else if (path_points_reg > 11'(MAX_PATH_POINTS))
            pts = 11'(MAX_PATH_POINTS);
        else
            pts = path_points_reg;
        pc_inc    = {1'b0, pc_reg} + 11'd1;
        last_load = (pc_inc >= pts);
        tv_full   = 34'(pc_reg) * 34'(tex_v_step_reg);
    end

    // Selected operands for the current component
    logic signed [17:0] m0_sel;
    logic signed [17:0] m1_sel;
    logic signed [31:0] off_sel;
    logic signed [31:0] ctr_sel;
    logic [37:0]        mag_sel;
    logic               neg_sel;

    always_comb
    begin
        case (cmd.comp)
            2'd0:
            begin
                m0_sel = mrx_reg[17:0];  m1_sel = mry_reg[17:0];
                off_sel = off_reg[0]; ctr_sel = ctr_reg[0];
                mag_sel = mag_reg[0]; neg_sel = neg_reg[0];
            end
            2'd1:
            begin
                m0_sel = mrx_reg[35:18]; m1_sel = mry_reg[35:18];
                off_sel = off_reg[1]; ctr_sel = ctr_reg[1];
                mag_sel = mag_reg[1]; neg_sel = neg_reg[1];
            end
            2'd2:
            begin
                m0_sel = mrx_reg[53:36]; m1_sel = mry_reg[53:36];
                off_sel = off_reg[2]; ctr_sel = ctr_reg[2];
                mag_sel = mag_reg[2]; neg_sel = neg_reg[2];
            end
            default:
            begin
                m0_sel = '0; m1_sel = '0; off_sel = '0; ctr_sel = '0;
                mag_sel = '0; neg_sel = 1'b0;
            end
        endcase
    end

    // Scaled circle sample
    logic signed [48:0] prod_x;
    logic signed [48:0] prod_y;
    logic signed [48:0] rnd_x;
    logic signed [48:0] rnd_y;

    assign prod_x = 49'(cos_tab[j_reg]) * 49'($signed({1'b0, sc_reg}));
    assign prod_y = 49'(sin_tab[j_reg]) * 49'($signed({1'b0, sc_reg}));
    assign rnd_x  = prod_x + 49'sd8192;
    assign rnd_y  = prod_y + 49'sd8192;

    // Position sum, rounding, offset from center
    logic signed [53:0] full;
    logic signed [53:0] full_r;
    logic signed [37:0] p;
    logic signed [38:0] d;
    logic [37:0]        mag_new;
    logic signed [31:0] pos_sat;

    always_comb
    begin
        full    = 54'(pa_reg) + 54'(pb_reg) + 54'($signed({off_sel, 16'b0}));
        full_r  = full + 54'sd32768;
        p       = 38'(full_r >>> 16);
        d       = 39'(p) - 39'(ctr_sel);
        mag_new = d[38] ? 38'(-d) : 38'(d);
        if (p > 38'sd2147483647)
            pos_sat = 32'sh7FFF_FFFF;
        else if (p < -38'sd2147483648)
            pos_sat = 32'sh8000_0000;
        else
            pos_sat = p[31:0];
    end

    // Square root and division step values
    logic [63:0] trial;
    logic [44:0] numer;
    logic [32:0] dtry;
    logic [31:0] len;
    logic [15:0] qn;

    assign len   = r_reg[31:0];
    assign trial = 64'(r_reg) + 64'(bit_reg);
    assign numer = {1'b0, mag_sel[29:0], 14'b0} + 45'(len >> 1);
    assign dtry  = {rem_reg, lo_reg[15]};
    assign qn    = (q_reg > 16'd16384) ? 16'd16384 : q_reg;

    // Status
    assign stat.mx_zero  = (mx_reg == '0);
    assign stat.mx_hi    = (mx_reg[37:30] != '0);
    assign stat.mx_lo    = !stat.mx_hi && !mx_reg[29];
    assign stat.j_last   = (j_reg == J_W'(RING_RES));
    assign stat.out_busy = out_valid_reg && !out_ready;

    // Configuration, point counter, sample index, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_points_reg    <= 11'd2;
            geometry_scale_reg <= 16'd256;
            tex_v_step_reg     <= 24'd196608;
            pc_reg             <= '0;
            j_reg              <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PATH_POINTS:    path_points_reg    <= cfg_data[10:0];
                    CFG_GEOMETRY_SCALE: geometry_scale_reg <= cfg_data[15:0];
                    CFG_TEX_V_STEP:     tex_v_step_reg     <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.load)
            begin
                pc_reg <= last_load ? '0 : pc_inc[PC_W-1:0];
                j_reg  <= '0;
            end
            else if (cmd.emit && !stat.j_last)
            begin
                j_reg <= j_reg + J_W'(1);
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Vertex arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mrx_reg    <= xform_row_x;
            mry_reg    <= xform_row_y;
            off_reg[0] <= offset_x;
            off_reg[1] <= offset_y;
            off_reg[2] <= offset_z;
            ctr_reg[0] <= center_x;
            ctr_reg[1] <= center_y;
            ctr_reg[2] <= center_z;
            sc_reg     <= 32'(geometry_scale_reg) * 32'(radius_factor);
            tv_reg     <= (tv_full > 34'hFF_FFFF) ? 24'hFF_FFFF : tv_full[23:0];
            base_reg   <= 20'(20'(pc_reg) * 20'(RING_RES + 1));
            last_reg   <= last_load;
        end
        // Scale the circle sample and clear the max
        if (cmd.lxy)
        begin
            lx_reg <= 34'(rnd_x >>> 14);
            ly_reg <= 34'(rnd_y >>> 14);
            mx_reg <= '0;
        end
        // Multiply by the transform column
        if (cmd.mul)
        begin
            pa_reg <= 52'(lx_reg) * 52'(m0_sel);
            pb_reg <= 52'(ly_reg) * 52'(m1_sel);
        end
        // Add, round, saturate, track max offset
        if (cmd.add)
        begin
            pos_reg[cmd.comp] <= pos_sat;
            mag_reg[cmd.comp] <= mag_new;
            neg_reg[cmd.comp] <= d[38];
            if (mag_new > mx_reg)
                mx_reg <= mag_new;
        end
        // Normalize the offsets one bit per cycle
        if (cmd.nrm_step)
        begin
            if (stat.mx_zero)
            begin
                for (int c = 0; c < 3; c++)
                    nrm_reg[c] <= '0;
            end
            else if (stat.mx_hi)
            begin
                mx_reg <= mx_reg >> 1;
                for (int c = 0; c < 3; c++)
                    mag_reg[c] <= mag_reg[c] >> 1;
            end
            else if (stat.mx_lo)
            begin
                mx_reg <= mx_reg << 1;
                for (int c = 0; c < 3; c++)
                    mag_reg[c] <= mag_reg[c] << 1;
            end
            else
            begin
                sq_reg  <= '0;
                acc_reg <= '0;
            end
        end
        // Sum of squares
        if (cmd.sq_step)
        begin
            sq_reg  <= 60'(mag_sel[29:0]) * 60'(mag_sel[29:0]);
            acc_reg <= acc_reg + 62'(sq_reg);
        end
        // Integer square root, one result bit per cycle
        if (cmd.sqrt_init)
        begin
            v_reg   <= acc_reg;
            r_reg   <= '0;
            bit_reg <= 63'(1) << 62;
        end
        if (cmd.sqrt_step)
        begin
            if (64'(v_reg) >= trial)
            begin
                v_reg <= 62'(64'(v_reg) - trial);
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        // Rounded division of each offset by the length
        if (cmd.div_init)
        begin
            rem_reg <= 32'(numer[44:16]);
            lo_reg  <= numer[15:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (dtry >= {1'b0, len})
            begin
                rem_reg <= 32'(dtry - {1'b0, len});
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= dtry[31:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
            lo_reg <= lo_reg << 1;
        end
        if (cmd.div_store)
        begin
            nrm_reg[cmd.comp] <= neg_sel ? -$signed(qn) : $signed(qn);
        end
        // Load the output word
        if (cmd.emit)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_pos_reg[c] <= pos_reg[c];
                out_nrm_reg[c] <= nrm_reg[c];
            end
            out_tu_reg   <= tu_tab[j_reg];
            out_tv_reg   <= tv_reg;
            out_qv_reg   <= !last_reg && !stat.j_last;
            out_qi_reg   <= (!last_reg && !stat.j_last) ? base_reg + 20'(j_reg) : '0;
            out_last_reg <= stat.j_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = out_pos_reg[0];
    assign pos_y      = out_pos_reg[1];
    assign pos_z      = out_pos_reg[2];
    assign nrm_x      = out_nrm_reg[0];
    assign nrm_y      = out_nrm_reg[1];
    assign nrm_z      = out_nrm_reg[2];
    assign tex_u      = out_tu_reg;
    assign tex_v      = out_tv_reg;
    assign quad_valid = out_qv_reg;
    assign quad_index = out_qi_reg;
    assign ring_last  = out_last_reg;

    // Squares start from an offset normalized to [2^29, 2^30)
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sq_step && cmd.comp == 2'd0) |-> (mx_reg[37:30] == '0 && mx_reg[29]))
        else $error("offset not normalized before squaring");

    // A normalized vector has a length of at least 2^29
    a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> (len[31:29] != 3'd0))
        else $error("length below normalized floor");

    // Normal components stay within one in Q1.14
    a_nrm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_store) |-> (qn <= 16'd16384))
        else $error("normal component out of range");

endmodule

[rtl/tube_sweep_mesh_generator.sv]
// Top level of the swept circle tube mesh generator.
`timescale 1ns / 1ps

// Usage:
// One input word per path point (transform rows, translation, center,
// radius factor) enters on in_valid/in_ready. For each point the block emits
// RING_RES+1 vertex words on out_valid/out_ready, last one flagged ring_last.
// Registers (path_points, geometry_scale, tex_v_step) are written on
// cfg_valid/cfg_ready at cfg_index; cfg_ready is always high. Write them only
// while the block is idle.
// Sequence: each vertex is computed by a sequencer over one shared datapath:
// transform, normalize check, sum of squares, square root, three 16-step
// divisions and output load, plus one normalizing shift step per bit of
// shift, up to 29 bits; when the vertex lands on the center the sequencer
// skips from the normalize check to the output load. The next point is
// taken in the idle state that follows the last vertex of a ring.
// Reset: asynchronous, active low; restores register defaults and clears the
// point counter. A stalled receiver holds the output word and the sequencer
// waits with the next vertex finished.
module tube_sweep_mesh_generator #(
    parameter int RING_RES        = 16,
    parameter int MAX_PATH_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [53:0]        xform_row_x,
    input  logic [53:0]        xform_row_y,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    input  logic signed [31:0] offset_z,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [15:0]        radius_factor,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] nrm_x,
    output logic signed [15:0] nrm_y,
    output logic signed [15:0] nrm_z,
    output logic [15:0]        tex_u,
    output logic [23:0]        tex_v,
    output logic               quad_valid,
    output logic [19:0]        quad_index,
    output logic               ring_last
);
    import tsm_pkg::*;

    tsm_cmd_t  cmd;
    tsm_stat_t stat;

    assign cfg_ready = 1'b1;

    tsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsm_dp #(
        .RING_RES        (RING_RES),
        .MAX_PATH_POINTS (MAX_PATH_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .xform_row_x   (xform_row_x),
        .xform_row_y   (xform_row_y),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .offset_z      (offset_z),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .radius_factor (radius_factor),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .nrm_x         (nrm_x),
        .nrm_y         (nrm_y),
        .nrm_z         (nrm_z),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .quad_valid    (quad_valid),
        .quad_index    (quad_index),
        .ring_last     (ring_last)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the swept circle tube mesh generator.
`timescale 1ns / 1ps

module tb;

    import tsm_pkg::*;

    localparam int RES = 16;
    localparam int MAXPTS = 1024;

    typedef struct {
        logic [53:0]        row_x;
        logic [53:0]        row_y;
        logic signed [31:0] off [3];
        logic signed [31:0] ctr [3];
        logic [15:0]        prof;
    } point_t;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [15:0] nrm [3];
        logic [15:0]        u;
        logic [23:0]        v;
        logic               qv;
        logic [19:0]        qi;
        logic               rlast;
    } vertex_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [53:0]        xform_row_x;
    logic [53:0]        xform_row_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [15:0]        radius_factor;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic [15:0]        tex_u;
    logic [23:0]        tex_v;
    logic               quad_valid;
    logic [19:0]        quad_index;
    logic               ring_last;

    // Predictor state and register copies
    longint      ring_cos [RES + 1];
    longint      ring_sin [RES + 1];
    logic [10:0] reg_points;
    logic [15:0] reg_scale;
    logic [23:0] reg_vstep;
    logic [9:0]  sweep_pos;

    point_t  pending_points [$];
    vertex_t expected_vertices [$];
    int      errors;
    int      in_gap_max;
    int      out_stall_max;
    int      in_gap;
    int      out_hold;
    bit      in_taken;

    tube_sweep_mesh_generator #(
        .RING_RES(RES),
        .MAX_PATH_POINTS(MAXPTS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .xform_row_x(xform_row_x), .xform_row_y(xform_row_y),
        .offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .radius_factor(radius_factor),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .quad_valid(quad_valid), .quad_index(quad_index), .ring_last(ring_last)
    );

    always #10 clk = ~clk;

    // Round to nearest, halves toward plus infinity
    function automatic longint rnd(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clampq14(input longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    // Build the unit circle table with a 16-step CORDIC
    task automatic build_circle();
        logic [31:0] a;
        logic [31:0] q;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        for (int k = 0; k < RES; k++)
        begin
            a = 32'((64'(k) << 32) / RES);
            q = ((a + 32'h2000_0000) >> 30) & 32'd3;
            z = longint'($signed(a - (q << 30)));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= CORDIC_ATAN[i];
                end
                else
                begin
                    x += dx; y -= dy; z += CORDIC_ATAN[i];
                end
            end
            case (q[1:0])
                2'd0:    begin c = x;  s = y;  end
                2'd1:    begin c = -y; s = x;  end
                2'd2:    begin c = -x; s = -y; end
                default: begin c = y;  s = -x; end
            endcase
            ring_cos[k] = clampq14(rnd(c, 16));
            ring_sin[k] = clampq14(rnd(s, 16));
        end
        ring_cos[RES] = ring_cos[0];
        ring_sin[RES] = ring_sin[0];
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Compute the ring of vertices for one path point and advance the sweep
    task automatic predict_ring(input point_t p);
        longint      m0 [3];
        longint      m1 [3];
        longint      lx;
        longint      ly;
        longint      sc;
        longint      full;
        longint      pv;
        longint      d;
        longint      tv;
        logic [63:0] mag [3];
        logic [63:0] mx;
        logic [63:0] len;
        logic [63:0] qn;
        bit          neg [3];
        int          pts;
        bit          last;
        vertex_t     vx;
        pts = reg_points;
        if (pts < 2)
            pts = 2;
        if (pts > MAXPTS)
            pts = MAXPTS;
        last = (int'(sweep_pos) + 1 >= pts);
        for (int c = 0; c < 3; c++)
        begin
            m0[c] = longint'($signed(p.row_x[18*c +: 18]));
            m1[c] = longint'($signed(p.row_y[18*c +: 18]));
        end
        sc = longint'(reg_scale) * longint'(p.prof);
        tv = longint'(sweep_pos) * longint'(reg_vstep);
        if (tv > 64'hFF_FFFF)
            tv = 64'hFF_FFFF;
        for (int j = 0; j <= RES; j++)
        begin
            lx = rnd(ring_cos[j] * sc, 14);
            ly = rnd(ring_sin[j] * sc, 14);
            mx = 0;
            for (int c = 0; c < 3; c++)
            begin
                full = lx * m0[c] + ly * m1[c] + longint'(p.off[c]) * 65536;
                pv = rnd(full, 16);
                if (pv > 64'sd2147483647)
                    vx.pos[c] = 32'sh7FFF_FFFF;
                else if (pv < -64'sd2147483648)
                    vx.pos[c] = 32'sh8000_0000;
                else
                    vx.pos[c] = pv[31:0];
                d = pv - longint'(p.ctr[c]);
                neg[c] = d < 0;
                mag[c] = neg[c] ? 64'(-d) : 64'(d);
                if (mag[c] > mx)
                    mx = mag[c];
            end
            if (mx == 0)
            begin
                for (int c = 0; c < 3; c++)
                    vx.nrm[c] = 0;
            end
            else
            begin
                // Normalize the largest component into [2^29, 2^30)
                while (mx >= (64'd1 << 30))
                begin
                    mx >>= 1;
                    for (int c = 0; c < 3; c++)
                        mag[c] >>= 1;
                end
                while (mx < (64'd1 << 29))
                begin
                    mx <<= 1;
                    for (int c = 0; c < 3; c++)
                        mag[c] <<= 1;
                end
                len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
                for (int c = 0; c < 3; c++)
                begin
                    qn = (mag[c] * 16384 + len / 2) / len;
                    if (qn > 16384)
                        qn = 16384;
                    vx.nrm[c] = neg[c] ? -16'(qn) : 16'(qn);
                end
            end
            vx.u = 16'((j * 32768 + RES / 2) / RES);
            vx.v = tv[23:0];
            vx.qv = !last && j < RES;
            vx.qi = vx.qv ? 20'(int'(sweep_pos) * (RES + 1) + j) : 20'd0;
            vx.rlast = (j == RES);
            expected_vertices.insert(expected_vertices.size(), vx);
        end
        sweep_pos = last ? 10'd0 : sweep_pos + 10'd1;
    endtask

    // Feed path points: hold until accepted, then wait a drawn gap
    always @(posedge clk)
    begin
        in_taken = in_valid && in_ready;
        if (in_taken)
            predict_ring('{row_x: xform_row_x, row_y: xform_row_y,
                           off: '{offset_x, offset_y, offset_z},
                           ctr: '{center_x, center_y, center_z},
                           prof: radius_factor});
    end

    always @(negedge clk)
    begin
        point_t p;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (in_gap > 0 || pending_points.size() == 0)
            begin
                if (in_gap > 0)
                    in_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                p = pending_points.pop_front();
                xform_row_x   <= p.row_x;
                xform_row_y   <= p.row_y;
                offset_x      <= p.off[0];
                offset_y      <= p.off[1];
                offset_z      <= p.off[2];
                center_x      <= p.ctr[0];
                center_y      <= p.ctr[1];
                center_z      <= p.ctr[2];
                radius_factor <= p.prof;
                in_valid      <= 1'b1;
                in_gap = $urandom_range(0, in_gap_max);
            end
            in_taken = 1'b0;
        end
    end

    // Stall the output side for a drawn number of cycles per word
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compare each vertex word with the oldest expectation
    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && out_valid && out_ready)
        begin
            out_hold = $urandom_range(0, out_stall_max);
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: vertex word with none expected, pos %0d %0d %0d",
                         $time, pos_x, pos_y, pos_z);
                errors++;
            end
            else
            begin
                e = expected_vertices.pop_front();
                check_field("pos_x", e.pos[0], pos_x);
                check_field("pos_y", e.pos[1], pos_y);
                check_field("pos_z", e.pos[2], pos_z);
                check_field("nrm_x", e.nrm[0], nrm_x);
                check_field("nrm_y", e.nrm[1], nrm_y);
                check_field("nrm_z", e.nrm[2], nrm_z);
                check_field("tex_u", e.u, tex_u);
                check_field("tex_v", e.v, tex_v);
                check_field("quad_valid", e.qv, quad_valid);
                check_field("quad_index", e.qi, quad_index);
                check_field("ring_last", e.rlast, ring_last);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PATH_POINTS:    reg_points = val[10:0];
            CFG_GEOMETRY_SCALE: reg_scale  = val[15:0];
            CFG_TEX_V_STEP:     reg_vstep  = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [10:0] pts, input logic [15:0] scl,
                             input logic [23:0] stp);
        write_reg(CFG_PATH_POINTS, 24'(pts));
        write_reg(CFG_GEOMETRY_SCALE, 24'(scl));
        write_reg(CFG_TEX_V_STEP, stp);
    endtask

    // Drain: every queued point taken and every vertex seen
    task automatic drain();
        while (pending_points.size() != 0 || in_valid || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [53:0] rand54();
        return 54'({$urandom, $urandom});
    endfunction

    // Random path point: mostly plausible sweeps, some raw noise
    function automatic point_t rand_point();
        point_t p;
        int     mode;
        mode = $urandom_range(0, 9);
        p.row_x = rand54();
        p.row_y = rand54();
        p.prof  = 16'($urandom);
        for (int c = 0; c < 3; c++)
        begin
            p.off[c] = $urandom;
            p.ctr[c] = $urandom;
        end
        if (mode == 1)
        begin
            // vertex lands on the center
            p.prof = 0;
            p.ctr  = p.off;
        end
        else if (mode >= 2)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p.row_x[18*c +: 18] = 18'($signed($urandom_range(0, 131072)) - 65536);
                p.row_y[18*c +: 18] = 18'($signed($urandom_range(0, 131072)) - 65536);
                p.off[c] = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
                p.ctr[c] = p.off[c] + $signed($urandom_range(0, 512)) - 256;
            end
            p.prof = 16'($urandom_range(0, 1024));
        end
        return p;
    endfunction

    task automatic add_point(input logic [53:0] rx, input logic [53:0] ry,
                             input logic signed [31:0] o, input logic signed [31:0] ct,
                             input logic [15:0] pr);
        point_t p;
        p.row_x = rx;
        p.row_y = ry;
        p.off   = '{o, o, o};
        p.ctr   = '{ct, ct, ct};
        p.prof  = pr;
        pending_points.insert(pending_points.size(), p);
    endtask

    initial
    begin
        point_t p;
        clk = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = CFG_PATH_POINTS;
        cfg_data = 0;
        in_valid = 0;
        out_ready = 0;
        xform_row_x = 0;
        xform_row_y = 0;
        offset_x = 0;
        offset_y = 0;
        offset_z = 0;
        center_x = 0;
        center_y = 0;
        center_z = 0;
        radius_factor = 0;
        errors = 0;
        in_gap = 0;
        out_hold = 0;
        in_taken = 0;
        in_gap_max = 6;
        out_stall_max = 6;
        reg_points = 2;
        reg_scale = 256;
        reg_vstep = 196608;
        sweep_pos = 0;
        build_circle();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Field extremes at the reset settings
        add_point(0, 0, 0, 0, 0);
        add_point({54{1'b1}}, {54{1'b1}}, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
        add_point({3{18'h20000}}, {3{18'h20000}}, 32'sh8000_0000, 32'sh8000_0000,
                  16'hFFFF);
        add_point({36'd0, 18'h10000}, {18'd0, 18'h10000, 18'd0}, 32'sh0001_0000,
                  32'sh0001_0000, 16'h0100);
        add_point({3{18'h1FFFF}}, {3{18'h1FFFF}}, 32'sh7FFF_0000, 0, 16'hFFFF);
        add_point({3{18'h15555}}, {3{18'h2AAAA}}, 32'sh5555_5555, 32'shAAAA_AAAA,
                  16'h5555);
        drain();

        // Point count below range, zero radius, saturating v step
        write_all(11'd0, 16'd0, 24'hFF_FFFF);
        for (int k = 0; k < 3; k++)
            pending_points.insert(pending_points.size(), rand_point());
        drain();

        // Point count above range, largest radius, zero step
        write_all(11'h7FF, 16'hFFFF, 24'd0);
        for (int k = 0; k < 3; k++)
            pending_points.insert(pending_points.size(), rand_point());
        drain();

        // Counter left past a shortened sweep
        write_all(11'd6, 16'd256, 24'd4096);
        for (int k = 0; k < 4; k++)
            pending_points.insert(pending_points.size(), rand_point());
        drain();
        write_reg(CFG_PATH_POINTS, 24'd1);
        for (int k = 0; k < 3; k++)
            pending_points.insert(pending_points.size(), rand_point());
        drain();
        write_reg(CFG_PATH_POINTS, 24'd1024);
        for (int k = 0; k < 3; k++)
            pending_points.insert(pending_points.size(), rand_point());
        drain();

        // Random phases with random settings
        for (int ph = 0; ph < 12; ph++)
        begin
            in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 6;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            write_all(($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, 12)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1024)),
                      ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65536)));
            for (int k = 0; k < 35; k++)
            begin
                p = rand_point();
                pending_points.insert(pending_points.size(), p);
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
